// ===== rtl/minkowski_support_point_defines.svh =====
// Assertion macros for the support point RTL.
`ifndef MINKOWSKI_SUPPORT_POINT_DEFINES_SVH
`define MINKOWSKI_SUPPORT_POINT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSP_ASSERT_IMP(lbl, ante, cons, msg)
`define MSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/msp_pkg.sv =====
// Package: constants, codes and types of the support point block.
`timescale 1ns / 1ps
package msp_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VERT_W       = 3 * COORD_BITS;
    localparam int PROD_W       = 2 * COORD_BITS;
    localparam int DOT_W        = PROD_W + 2;
    localparam int OUT_W        = COORD_BITS + 1;

    // Item modes (any other code is a query)
    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;

    // Result status codes
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_SUPPORT = 2'd2;

    // Control from the sequencer to one scan lane
    typedef struct packed {
        logic clear;     // start of a query: forget the best so far
        logic rd_valid;  // read data this cycle belongs to the scan
        logic find_min;  // pick the smallest dot product, not the largest
    } lane_ctrl_t;

endpackage

// ===== rtl/minkowski_support_point.sv =====
// Top level: vertex stores, query sequencer and result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------
//  input   | in_valid  | in_stall  | mode, restart, x, y, z
//  output  | out_valid | out_stall | status, sx, sy, sz
//
// A load goes through S_OUT to the output register; the vertex is written at
// the input transfer. A query scans max(count A, count B) entries: both
// stores are read in step through one read port each, one entry a cycle.
// Reset empties both stores (counts to zero); no clearing pass is needed.
// A finished result waits in the output register while the next item is
// taken; only a second result behind a stalled one holds the sequencer.
`timescale 1ns / 1ps
`include "minkowski_support_point_defines.svh"
module minkowski_support_point
    import msp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               mode,
    input  logic                     restart,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    input  logic signed [COORD_BITS-1:0] z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic signed [OUT_W-1:0]  sx,
    output logic signed [OUT_W-1:0]  sy,
    output logic signed [OUT_W-1:0]  sz
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_a_reg, count_b_reg, scan_len_reg, scan_idx_reg;
    logic [CNT_W-1:0] cnt_eff_a, cnt_eff_b;
    logic             rd_valid_a_reg, rd_valid_b_reg;
    logic signed [COORD_BITS-1:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [1:0]       res_status_reg;
    logic signed [OUT_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic signed [OUT_W-1:0] sx_reg, sy_reg, sz_reg;

    logic in_xfer, is_load_a, is_load_b, is_query;
    logic full_a, full_b, we_a, we_b;
    logic issuing, scan_done, out_free;
    logic [VERT_W-1:0] wdata, rdata_a, rdata_b, best_a, best_b;
    logic busy_a, busy_b;
    lane_ctrl_t ctrl_a, ctrl_b;
    logic signed [OUT_W-1:0] diff_x, diff_y, diff_z;

    // Input decode
    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign is_load_a = (mode == MODE_LOAD_A);
    assign is_load_b = (mode == MODE_LOAD_B);
    assign is_query  = !is_load_a && !is_load_b;

    // Store write: restart empties the store before the append
    assign cnt_eff_a = restart ? '0 : count_a_reg;
    assign cnt_eff_b = restart ? '0 : count_b_reg;
    assign full_a    = (cnt_eff_a == CNT_W'(MAX_VERTICES));
    assign full_b    = (cnt_eff_b == CNT_W'(MAX_VERTICES));
    assign we_a      = in_xfer && is_load_a && !full_a;
    assign we_b      = in_xfer && is_load_b && !full_b;
    assign wdata     = {x, y, z};

    msp_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_eff_a[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (scan_idx_reg[ADDR_W-1:0]),
        .rdata (rdata_a)
    );

    msp_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_eff_b[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (scan_idx_reg[ADDR_W-1:0]),
        .rdata (rdata_b)
    );

    // Scan lanes; B takes the smallest dot with d, i.e. largest with -d
    assign ctrl_a = '{clear: in_xfer && is_query, rd_valid: rd_valid_a_reg, find_min: 1'b0};
    assign ctrl_b = '{clear: in_xfer && is_query, rd_valid: rd_valid_b_reg, find_min: 1'b1};

    msp_lane u_lane_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_a),
        .dir_x   (dir_x_reg),
        .dir_y   (dir_y_reg),
        .dir_z   (dir_z_reg),
        .rd_data (rdata_a),
        .best    (best_a),
        .busy    (busy_a)
    );

    msp_lane u_lane_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_b),
        .dir_x   (dir_x_reg),
        .dir_y   (dir_y_reg),
        .dir_z   (dir_z_reg),
        .rd_data (rdata_b),
        .best    (best_b),
        .busy    (busy_b)
    );

    assign issuing   = (state_reg == S_SCAN) && (scan_idx_reg < scan_len_reg);
    assign scan_done = !issuing && !rd_valid_a_reg && !rd_valid_b_reg && !busy_a && !busy_b;
    assign out_free  = !out_valid_reg || !out_stall;

    // Support point: A's best minus B's best
    assign diff_x = OUT_W'(signed'(best_a[VERT_W-1 -: COORD_BITS]))
                  - OUT_W'(signed'(best_b[VERT_W-1 -: COORD_BITS]));
    assign diff_y = OUT_W'(signed'(best_a[2*COORD_BITS-1 -: COORD_BITS]))
                  - OUT_W'(signed'(best_b[2*COORD_BITS-1 -: COORD_BITS]));
    assign diff_z = OUT_W'(signed'(best_a[COORD_BITS-1:0]))
                  - OUT_W'(signed'(best_b[COORD_BITS-1:0]));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = is_query ? S_SCAN : S_OUT;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            scan_idx_reg   <= '0;
            scan_len_reg   <= '0;
            rd_valid_a_reg <= 1'b0;
            rd_valid_b_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer && is_load_a)
            begin
                count_a_reg <= full_a ? cnt_eff_a : cnt_eff_a + 1'b1;
            end
            if (in_xfer && is_load_b)
            begin
                count_b_reg <= full_b ? cnt_eff_b : cnt_eff_b + 1'b1;
            end
            if (in_xfer && is_query)
            begin
                scan_idx_reg <= '0;
                scan_len_reg <= (count_a_reg > count_b_reg) ? count_a_reg : count_b_reg;
            end
            else if (issuing)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            rd_valid_a_reg <= issuing && (scan_idx_reg < count_a_reg);
            rd_valid_b_reg <= issuing && (scan_idx_reg < count_b_reg);
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Direction and pending result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            dir_x_reg      <= x;
            dir_y_reg      <= y;
            dir_z_reg      <= z;
            res_status_reg <= (is_load_a && full_a) || (is_load_b && full_b)
                              ? ST_DROPPED : ST_STORED;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_z_reg      <= '0;
        end
        else if (state_reg == S_SCAN && scan_done)
        begin
            res_status_reg <= ST_SUPPORT;
            res_x_reg      <= diff_x;
            res_y_reg      <= diff_y;
            res_z_reg      <= diff_z;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            status_reg <= res_status_reg;
            sx_reg     <= res_x_reg;
            sy_reg     <= res_y_reg;
            sz_reg     <= res_z_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign sx        = sx_reg;
    assign sy        = sy_reg;
    assign sz        = sz_reg;

    // Checks
    `MSP_ASSERT_IMP(a_count_a_range, 1'b1, count_a_reg <= CNT_W'(MAX_VERTICES), "count A overflow")
    `MSP_ASSERT_IMP(a_count_b_range, 1'b1, count_b_reg <= CNT_W'(MAX_VERTICES), "count B overflow")
    `MSP_ASSERT_IMP(a_read_in_scan, rd_valid_a_reg || rd_valid_b_reg, state_reg == S_SCAN, "read outside scan")
    `MSP_ASSERT_NXT(a_query_scans, in_xfer && is_query, state_reg == S_SCAN, "query did not start scan")
    `MSP_ASSERT_IMP(a_scan_bound, issuing, scan_idx_reg < CNT_W'(MAX_VERTICES), "scan index past store")

endmodule

// ===== rtl/msp_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/msp_lane.sv =====
// Scan lane: pipelined exact dot product and running extreme over one store.
`timescale 1ns / 1ps
module msp_lane
    import msp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lane_ctrl_t                   ctrl,
    input  logic signed [COORD_BITS-1:0] dir_x,
    input  logic signed [COORD_BITS-1:0] dir_y,
    input  logic signed [COORD_BITS-1:0] dir_z,
    input  logic [VERT_W-1:0]            rd_data,
    output logic [VERT_W-1:0]            best,
    output logic                         busy
);

    logic signed [COORD_BITS-1:0] vx, vy, vz;
    logic signed [PROD_W-1:0]     px_reg, py_reg, pz_reg;
    logic [VERT_W-1:0]            v1_reg, v2_reg, best_reg;
    logic                         s1_valid_reg, s2_valid_reg, have_reg;
    logic signed [DOT_W-1:0]      dot_reg, best_dot_reg;
    logic                         better;

    assign vx = rd_data[VERT_W-1 -: COORD_BITS];
    assign vy = rd_data[2*COORD_BITS-1 -: COORD_BITS];
    assign vz = rd_data[COORD_BITS-1:0];

    // Stage valids and the have-a-candidate flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.rd_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    // Stage 1: three products
    always_ff @(posedge clk)
    begin
        px_reg <= vx * dir_x;
        py_reg <= vy * dir_y;
        pz_reg <= vz * dir_z;
        v1_reg <= rd_data;
    end

    // Stage 2: exact sum
    always_ff @(posedge clk)
    begin
        dot_reg <= DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        v2_reg  <= v1_reg;
    end

    // Stage 3: strict compare keeps the first extreme on ties
    assign better = ctrl.find_min ? (dot_reg < best_dot_reg) : (dot_reg > best_dot_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            best_reg <= '0;
        end
        else if (s2_valid_reg && (!have_reg || better))
        begin
            best_reg     <= v2_reg;
            best_dot_reg <= dot_reg;
        end
    end

    assign best = best_reg;
    assign busy = s1_valid_reg | s2_valid_reg;

endmodule

// ===== tb/minkowski_support_point_tb.sv =====
// Testbench for the Minkowski-difference support point block.
`timescale 1ns / 1ps
module minkowski_support_point_tb;
    import msp_pkg::*;

    // Query codes; the spare mode code is decoded as a query too
    localparam logic [1:0] MODE_QUERY     = 2'd2;
    localparam logic [1:0] MODE_QUERY_ALT = 2'd3;

    localparam int     RANDOM_ITEMS  = 160;
    localparam int     SETTLE_CYCLES = MAX_VERTICES + 40;
    localparam longint CYCLE_LIMIT   = 2_000_000;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [OUT_W-1:0]      point_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    typedef struct packed {
        logic [1:0] status;
        point_t     sx;
        point_t     sy;
        point_t     sz;
    } support_result_t;

    // Mesh stores, counts and the queue of support results still owed
    class support_scoreboard;
        vertex_t         mesh [2][MAX_VERTICES];
        int              count [2];
        support_result_t queued [$];
        int              errors;

        function new();
            count[0] = 0;
            count[1] = 0;
            errors   = 0;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // First vertex with the largest exact dot product; origin if empty
        function vertex_t furthest(int sel, longint dx, longint dy, longint dz);
            vertex_t best;
            longint  best_dot;
            longint  dot;
            best     = '0;
            best_dot = 0;
            for (int i = 0; i < count[sel]; i++)
            begin
                dot = longint'(mesh[sel][i].x) * dx + longint'(mesh[sel][i].y) * dy
                    + longint'(mesh[sel][i].z) * dz;
                if (i == 0 || dot > best_dot)
                begin
                    best     = mesh[sel][i];
                    best_dot = dot;
                end
            end
            return best;
        endfunction

        // Work out the result of an accepted input transfer
        function void note_input(logic [1:0] m, logic rs, vertex_t v);
            support_result_t r;
            vertex_t         pa;
            vertex_t         pb;
            int              sel;
            r = '0;
            if (m == MODE_LOAD_A || m == MODE_LOAD_B)
            begin
                sel = (m == MODE_LOAD_B) ? 1 : 0;
                if (rs)
                begin
                    count[sel] = 0;
                end
                if (count[sel] >= MAX_VERTICES)
                begin
                    r.status = ST_DROPPED;
                end
                else
                begin
                    mesh[sel][count[sel]] = v;
                    count[sel]++;
                    r.status = ST_STORED;
                end
            end
            else
            begin
                // A along d, B along -d
                pa = furthest(0, v.x, v.y, v.z);
                pb = furthest(1, -longint'(v.x), -longint'(v.y), -longint'(v.z));
                r.status = ST_SUPPORT;
                r.sx = OUT_W'(longint'(pa.x) - longint'(pb.x));
                r.sy = OUT_W'(longint'(pa.y) - longint'(pb.y));
                r.sz = OUT_W'(longint'(pa.z) - longint'(pb.z));
            end
            queued.insert(queued.size(), r);
        endfunction

        // Compare an output transfer with the oldest result owed
        task check_result(support_result_t got);
            support_result_t want;
            if (queued.size() == 0)
            begin
                report($sformatf("result with nothing owed, status %0d", got.status));
                return;
            end
            want = queued.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.sx !== want.sx)
                report($sformatf("sx %0d, want %0d", got.sx, want.sx));
            if (got.sy !== want.sy)
                report($sformatf("sy %0d, want %0d", got.sy, want.sy));
            if (got.sz !== want.sz)
                report($sformatf("sz %0d, want %0d", got.sz, want.sz));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    logic [1:0]   mode;
    logic         restart;
    coord_t       x;
    coord_t       y;
    coord_t       z;
    logic         out_valid;
    logic         out_stall;
    logic [1:0]   status;
    point_t       sx;
    point_t       sy;
    point_t       sz;

    support_scoreboard sb = new();
    bit                burst;        // no idling on either side while set
    vertex_t           last_vertex;  // reused now and then to force ties
    int                sent;
    longint            cycles;

    minkowski_support_point u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .restart   (restart),
        .x         (x),
        .y         (y),
        .z         (z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .sx        (sx),
        .sy        (sy),
        .sz        (sz)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** minkowski_support_point: FAILED **");
            $finish;
        end
    end

    function automatic vertex_t vtx(int a, int b, int c);
        return '{coord_t'(a), coord_t'(b), coord_t'(c)};
    endfunction

    // Extremes, tiny values near zero, or anything at all
    function automatic coord_t rand_coord();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            case ($urandom_range(0, 4))
                0: return coord_t'(-32768);
                1: return coord_t'(32767);
                2: return coord_t'(0);
                3: return coord_t'(-1);
                default: return coord_t'(1);
            endcase
        end
        else if (sel <= 2)
            return coord_t'(int'($urandom_range(0, 8)) - 4);
        return coord_t'($urandom);
    endfunction

    function automatic vertex_t rand_vertex();
        return '{rand_coord(), rand_coord(), rand_coord()};
    endfunction

    // One input transfer, after a random gap
    task automatic send_item(logic [1:0] m, logic rs, vertex_t v);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        restart  <= rs;
        x        <= v.x;
        y        <= v.y;
        z        <= v.z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(m, rs, v);
        sent++;
    endtask

    task automatic load_vertex(logic [1:0] m, logic rs);
        vertex_t v;
        v = ($urandom_range(0, 5) == 0) ? last_vertex : rand_vertex();
        last_vertex = v;
        send_item(m, rs, v);
    endtask

    task automatic send_query();
        logic [1:0] m;
        m = ($urandom_range(0, 4) == 0) ? MODE_QUERY_ALT : MODE_QUERY;
        send_item(m, 1'($urandom_range(0, 1)), rand_vertex());
    endtask

    // Output side: random stall before each transfer, then check it
    initial
    begin : result_side
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = burst ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_result('{status, sx, sy, sz});
        end
    end

    initial
    begin : stimulus
        int kind;
        int na;
        int nb;
        int target;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        mode     <= MODE_LOAD_A;
        restart  <= 1'b0;
        x        <= '0;
        y        <= '0;
        z        <= '0;
        burst       = 1'b0;
        sent        = 0;
        cycles      = 0;
        last_vertex = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty stores, extremes, ties, restart, spare mode code
        send_item(MODE_QUERY, 1'b0, vtx(1, 2, 3));
        send_item(MODE_QUERY_ALT, 1'b1, vtx(32767, 0, -32768));
        send_item(MODE_LOAD_A, 1'b1, vtx(-32768, -32768, -32768));
        send_item(MODE_QUERY, 1'b0, vtx(-1, -1, -1));
        send_item(MODE_LOAD_A, 1'b0, vtx(32767, 32767, 32767));
        send_item(MODE_LOAD_A, 1'b0, vtx(32767, 32767, 32767));
        send_item(MODE_LOAD_B, 1'b1, vtx(0, 0, 0));
        send_item(MODE_LOAD_B, 1'b0, vtx(-32768, 32767, -1));
        send_item(MODE_QUERY, 1'b0, vtx(1, 1, 1));
        send_item(MODE_QUERY, 1'b0, vtx(-32768, -32768, -32768));
        send_item(MODE_QUERY, 1'b1, vtx(32767, 32767, 32767));
        send_item(MODE_QUERY, 1'b0, vtx(0, 0, 0));
        send_item(MODE_QUERY_ALT, 1'b0, vtx(-32768, 32767, 0));
        // widest differences, both signs
        send_item(MODE_LOAD_A, 1'b1, vtx(-32768, -32768, -32768));
        send_item(MODE_LOAD_B, 1'b1, vtx(32767, 32767, 32767));
        send_item(MODE_QUERY, 1'b0, vtx(1, 0, 0));
        send_item(MODE_LOAD_A, 1'b1, vtx(32767, 32767, 32767));
        send_item(MODE_LOAD_B, 1'b1, vtx(-32768, -32768, -32768));
        send_item(MODE_QUERY, 1'b0, vtx(0, -1, 32767));

        // Both stores filled, overfilled, queried, then restarted while full
        load_vertex(MODE_LOAD_A, 1'b1);
        repeat (MAX_VERTICES + 1) load_vertex(MODE_LOAD_A, 1'b0);
        load_vertex(MODE_LOAD_B, 1'b1);
        repeat (MAX_VERTICES) load_vertex(MODE_LOAD_B, 1'b0);
        repeat (6) send_query();
        send_item(MODE_QUERY, 1'b0, vtx(0, 0, 0));
        load_vertex(MODE_LOAD_A, 1'b1);
        send_query();
        load_vertex(MODE_LOAD_B, 1'b1);
        send_query();

        // Random: mostly load-then-query sequences, some appends and noise
        target = sent + RANDOM_ITEMS;
        while (sent < target)
        begin
            burst = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                na = $urandom_range(1, 8);
                nb = $urandom_range(1, 8);
                load_vertex(MODE_LOAD_A, 1'b1);
                repeat (na - 1) load_vertex(MODE_LOAD_A, 1'b0);
                load_vertex(MODE_LOAD_B, 1'b1);
                repeat (nb - 1) load_vertex(MODE_LOAD_B, 1'b0);
                repeat ($urandom_range(1, 6)) send_query();
            end
            else if (kind <= 8)
            begin
                repeat ($urandom_range(1, 4))
                    load_vertex($urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A, 1'b0);
                repeat ($urandom_range(1, 3)) send_query();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              rand_vertex());
            end
        end
        burst = 1'b0;

        // Drain, then give any stray result time to show
        in_valid <= 1'b0;
        while (sb.queued.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("** minkowski_support_point: PASSED **");
        else
            $display("** minkowski_support_point: FAILED **");
        $finish;
    end

endmodule
